// File: hw/rtl/eprom_pin_level_emulator_defines.svh
// Assertion macros for the EPROM emulator checker.
`ifndef EPROM_PIN_LEVEL_EMULATOR_DEFINES_SVH
`define EPROM_PIN_LEVEL_EMULATOR_DEFINES_SVH

// Clocked assertion, masked while reset is asserted.
`define EPLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define EPLE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/eple_pkg.sv
// Types and constants of the EPROM pin-level emulator.
package eple_pkg;

    localparam int SIZE_W = 23;
    localparam int ADDR_W = 22;
    localparam int DATA_W = 16;
    localparam int CNT_W  = 3;

    localparam logic [SIZE_W-1:0] SIZE_2K   = 23'h000800;
    localparam logic [SIZE_W-1:0] SIZE_8K   = 23'h002000;
    localparam logic [SIZE_W-1:0] SIZE_16K  = 23'h004000;
    localparam logic [SIZE_W-1:0] SIZE_128K = 23'h020000;
    localparam logic [SIZE_W-1:0] SIZE_256K = 23'h040000;
    localparam logic [SIZE_W-1:0] SIZE_2M   = 23'h200000;
    localparam logic [SIZE_W-1:0] SIZE_4M   = 23'h400000;

    localparam logic [DATA_W-1:0] WORD_ONES  = 16'hFFFF;
    localparam logic [DATA_W-1:0] ERASE_BYTE = 16'h00FF;
    localparam logic [CNT_W-1:0]  CNT_LIMIT  = 3'd5;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_EXEC
    } eple_state_t;

    typedef struct packed {
        logic accept;
        logic finish;
        logic sweep;
        logic sweep_clear;
    } eple_cmd_t;

    typedef struct packed {
        logic cfg_change;
        logic erase_hit;
        logic sweep_last;
    } eple_status_t;

endpackage

// File: hw/rtl/eple_if.sv
// Pin-snapshot and result channel interfaces.
interface eple_in_if;
    logic        valid;
    logic        ready;
    logic        supply_on;
    logic        prog_voltage;
    logic        chip_enable;
    logic        write_enable;
    logic        output_enable;
    logic [21:0] address;
    logic [15:0] write_data;

    modport source (
        output valid, supply_on, prog_voltage, chip_enable, write_enable,
               output_enable, address, write_data,
        input  ready
    );
    modport sink (
        input  valid, supply_on, prog_voltage, chip_enable, write_enable,
               output_enable, address, write_data,
        output ready
    );
endinterface

interface eple_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic        read_done;
    logic        write_done;
    logic        range_error;
    logic        erased;

    modport source (
        output valid, read_data, read_done, write_done, range_error, erased,
        input  ready
    );
    modport sink (
        input  valid, read_data, read_done, write_done, range_error, erased,
        output ready
    );
endinterface

// File: hw/rtl/eple_ctrl.sv
// Controller: sequences accept, execute and memory sweep.
module eple_ctrl
    import eple_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  eple_status_t status,
    output eple_cmd_t    cmd
);

    eple_state_t state_reg;
    eple_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (status.cfg_change)
                begin
                    // restart the pass for the new chip size
                    cmd.sweep_clear = 1'b1;
                end
                else if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = !status.cfg_change;
                if (status.cfg_change)
                begin
                    cmd.sweep_clear = 1'b1;
                    state_next      = ST_SWEEP;
                end
                else if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold until the result register can take the beat
                if (slot_free)
                begin
                    cmd.finish = 1'b1;
                    if (status.erase_hit)
                    begin
                        cmd.sweep_clear = 1'b1;
                        state_next      = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: hw/rtl/eple_dp.sv
// Datapath: cell memory, pin decode, write counters and result register.
module eple_dp
    import eple_pkg::*;
#(
    parameter int MEM_DEPTH = 65536
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    input  logic              supply_on,
    input  logic              prog_voltage,
    input  logic              chip_enable,
    input  logic              write_enable,
    input  logic              output_enable,
    input  logic [ADDR_W-1:0] address,
    input  logic [DATA_W-1:0] write_data,
    input  eple_cmd_t         cmd,
    output eple_status_t      status,
    output logic [DATA_W-1:0] read_data,
    output logic              read_done,
    output logic              write_done,
    output logic              range_error,
    output logic              erased
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam logic [SIZE_W-1:0] DEPTH_LIM = SIZE_W'(MEM_DEPTH);
    localparam logic [AW-1:0]     LAST_IDX  = AW'(MEM_DEPTH - 1);

    logic [DATA_W-1:0] mem [MEM_DEPTH];

    logic [SIZE_W-1:0] size_reg;
    logic              vdd_reg, vpp_reg, ce_reg, we_reg, oe_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] data_reg;
    logic              ok_reg;
    logic [DATA_W-1:0] mem_q_reg;
    logic [ADDR_W-1:0] prev_addr_reg;
    logic              prev_seen_reg;
    logic [CNT_W-1:0]  ep_cnt_reg, ep_cnt_next;
    logic [CNT_W-1:0]  ow_cnt_reg, ow_cnt_next;
    logic [AW-1:0]     sweep_cnt_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic              rd_done_reg, wr_done_reg, rerr_reg, erased_reg;

    logic              in_ok;
    logic              pgm;
    logic              is_read, is_write;
    logic              is_pattern;
    logic [CNT_W-1:0]  ep_inc, ow_inc;
    logic              erase_hit;
    logic              mem_we;
    logic [AW-1:0]     wr_idx;
    logic [DATA_W-1:0] wr_word, new_word;

    // address valid against both the chip size and the array depth
    assign in_ok = ({1'b0, address} < size_reg) && ({1'b0, address} < DEPTH_LIM);

    always_comb
    begin
        if (size_reg <= SIZE_2K)
        begin
            pgm = !we_reg;
        end
        else if (size_reg inside {SIZE_8K, SIZE_16K, SIZE_128K, SIZE_256K})
        begin
            pgm = we_reg;
        end
        else if (size_reg inside {SIZE_2M, SIZE_4M})
        begin
            pgm = oe_reg ? 1'b0 : we_reg;
        end
        else
        begin
            pgm = oe_reg ? !we_reg : we_reg;
        end
    end

    assign is_read  = vdd_reg && ce_reg && !pgm && oe_reg;
    assign is_write = !is_read && vdd_reg && vpp_reg && ce_reg && pgm && !oe_reg;

    assign is_pattern = (addr_reg == '0) &&
                        (data_reg == ERASE_BYTE || data_reg == WORD_ONES);
    assign ep_inc    = ep_cnt_reg + CNT_W'(is_pattern);
    assign ow_inc    = ow_cnt_reg + CNT_W'(!is_pattern);
    assign erase_hit = is_write && (ep_inc > CNT_LIMIT);

    always_comb
    begin
        ep_cnt_next = ep_cnt_reg;
        ow_cnt_next = ow_cnt_reg;
        if (cfg_we && cfg_wdata != size_reg)
        begin
            ep_cnt_next = '0;
            ow_cnt_next = '0;
        end
        else if (cmd.finish && is_write)
        begin
            ep_cnt_next = (ep_inc > CNT_LIMIT) ? '0 : ep_inc;
            ow_cnt_next = ow_inc;
            if (ow_inc > CNT_LIMIT)
            begin
                ow_cnt_next = '0;
                ep_cnt_next = '0;
            end
        end
    end

    assign status.cfg_change = cfg_we && (cfg_wdata != size_reg);
    assign status.erase_hit  = erase_hit;
    assign status.sweep_last = (sweep_cnt_reg == LAST_IDX);

    // full replace on the first program or a repeat address, else only clear bits
    assign new_word = (!prev_seen_reg || addr_reg == prev_addr_reg) ?
                      data_reg : (mem_q_reg & data_reg);
    assign mem_we   = cmd.sweep || (cmd.finish && is_write && ok_reg);
    assign wr_idx   = cmd.sweep ? sweep_cnt_reg : addr_reg[AW-1:0];
    assign wr_word  = cmd.sweep ? WORD_ONES : new_word;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_idx] <= wr_word;
        end
        if (cmd.accept && in_ok)
        begin
            mem_q_reg <= mem[address[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            vdd_reg  <= supply_on;
            vpp_reg  <= prog_voltage;
            ce_reg   <= chip_enable;
            we_reg   <= write_enable;
            oe_reg   <= output_enable;
            addr_reg <= address;
            data_reg <= write_data;
            ok_reg   <= in_ok;
        end
        if (cmd.finish)
        begin
            rdata_reg   <= (is_read && ok_reg) ? mem_q_reg : WORD_ONES;
            rd_done_reg <= is_read;
            wr_done_reg <= is_write;
            rerr_reg    <= (is_read || is_write) && !ok_reg;
            erased_reg  <= erase_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= '0;
            prev_addr_reg <= '0;
            prev_seen_reg <= 1'b0;
            ep_cnt_reg    <= '0;
            ow_cnt_reg    <= '0;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
            if (cmd.finish && is_write && ok_reg)
            begin
                prev_addr_reg <= addr_reg;
                prev_seen_reg <= 1'b1;
            end
            ep_cnt_reg <= ep_cnt_next;
            ow_cnt_reg <= ow_cnt_next;
            if (cmd.sweep_clear)
            begin
                sweep_cnt_reg <= '0;
            end
            else if (cmd.sweep && sweep_cnt_reg != LAST_IDX)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + AW'(1);
            end
        end
    end

    assign read_data   = rdata_reg;
    assign read_done   = rd_done_reg;
    assign write_done  = wr_done_reg;
    assign range_error = rerr_reg;
    assign erased      = erased_reg;

endmodule

// File: hw/rtl/eprom_pin_level_emulator.sv
// Top level of the 27xxx EPROM pin-level emulator.
// Usage:
//   in_ch carries one pin snapshot per beat (VDD, VPP, CE, WE/PGM, OE,
//   address, data bus). out_ch returns exactly one result beat per input
//   beat: read word, read/program cycle flags, range error, erase flag.
//   cfg_we/cfg_wdata write the chip size in words; write it only while the
//   block is idle. A new size selects the WE/PGM polarity and the valid
//   range, and refills the cell array with ones.
// Item flow:
//   The accept edge latches the snapshot and issues the cell read; the
//   commit edge then does the read-modify-write and loads the result
//   register. The commit waits while an untaken result still holds the
//   register, and a new snapshot is taken only after the commit.
// Reset and sweep:
//   After reset, after a size change and after a full erase the block walks
//   the cell memory, one word a cycle, over all MEM_DEPTH words (65536 by
//   default) and holds in_ch.ready low meanwhile. A result may still drain.
// Stall:
//   A finished result waits in the output register; the next snapshot is
//   still accepted, and its commit holds until out_ch takes the prior beat.
module eprom_pin_level_emulator
    import eple_pkg::*;
#(
    parameter int MEM_DEPTH = 65536
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    eple_in_if.sink           in_ch,
    eple_out_if.source        out_ch
);

    eple_cmd_t    cmd;
    eple_status_t status;

    // sequencing: accept, commit, memory sweep
    eple_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // cell array, decode and result register
    eple_dp #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .supply_on     (in_ch.supply_on),
        .prog_voltage  (in_ch.prog_voltage),
        .chip_enable   (in_ch.chip_enable),
        .write_enable  (in_ch.write_enable),
        .output_enable (in_ch.output_enable),
        .address       (in_ch.address),
        .write_data    (in_ch.write_data),
        .cmd           (cmd),
        .status        (status),
        .read_data     (out_ch.read_data),
        .read_done     (out_ch.read_done),
        .write_done    (out_ch.write_done),
        .range_error   (out_ch.range_error),
        .erased        (out_ch.erased)
    );

endmodule

// File: hw/rtl/eple_checker.sv
// Port-level checker for the EPROM emulator, bound to the top level.
`include "eprom_pin_level_emulator_defines.svh"

module eple_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] read_data,
    input logic        read_done,
    input logic        write_done,
    input logic        range_error,
    input logic        erased
);

    `EPLE_ASSERT_ALWAYS(a_sweep_after_reset, !rst_n |=> !in_ready, "ready right after reset")

    `EPLE_ASSERT(a_hold_stalled, out_valid && !out_ready |=> out_valid && $stable(read_data), "stalled beat changed")

    `EPLE_ASSERT(a_one_cycle_kind, out_valid |-> !(read_done && write_done), "read and program in one beat")

    `EPLE_ASSERT(a_erase_on_program, out_valid && erased |-> write_done && !read_done, "erase without program cycle")

    `EPLE_ASSERT(a_data_only_on_read, out_valid && read_data != 16'hFFFF |-> read_done && !range_error, "data without valid read")

endmodule

bind eprom_pin_level_emulator eple_checker u_eple_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .read_data   (out_ch.read_data),
    .read_done   (out_ch.read_done),
    .write_done  (out_ch.write_done),
    .range_error (out_ch.range_error),
    .erased      (out_ch.erased)
);

// File: test/tb.sv
// Self-checking testbench: random and directed pin snapshots against a scoreboard.
module tb
    import eple_pkg::*;
();

    localparam int MEM_DEPTH   = 65536;
    localparam int IDLE_PCT    = 33;
    // Cycles with no beat accepted on either side before the run is abandoned.
    // A memory sweep alone walks all MEM_DEPTH words, so allow several sweeps.
    localparam int STALL_LIMIT = 4 * MEM_DEPTH;
    localparam int BEATS_PER_PHASE = 190;
    localparam int PHASES = 8;

    localparam logic [SIZE_W-1:0] SIZE_NONE  = '0;
    localparam logic [SIZE_W-1:0] SIZE_SUB2K = 23'h0007FF;
    localparam logic [SIZE_W-1:0] SIZE_ODD   = 23'h00ABCD;

    typedef struct {
        logic              supply_on;
        logic              prog_voltage;
        logic              chip_enable;
        logic              write_enable;
        logic              output_enable;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } pin_beat_t;

    typedef struct {
        logic [DATA_W-1:0] read_data;
        logic              read_done;
        logic              write_done;
        logic              range_error;
        logic              erased;
    } result_beat_t;

    typedef enum int {
        OP_READ,
        OP_PROG,
        OP_NOISE
    } pin_op_t;

    // Predicts the emulated EPROM and checks its result beats in order.
    class eprom_scoreboard;
        logic [DATA_W-1:0] cells [int unsigned];   // absent words read as all ones
        logic [SIZE_W-1:0] chip_size;
        logic [ADDR_W-1:0] last_prog_addr;
        bit                last_prog_seen;
        int unsigned       erase_hits;
        int unsigned       other_progs;
        result_beat_t      awaited[$];
        int                errors;

        function new();
            chip_size      = SIZE_NONE;
            last_prog_addr = '0;
            last_prog_seen = 1'b0;
            erase_hits     = 0;
            other_progs    = 0;
            errors         = 0;
        endfunction

        // A new size blanks the array and both counters; the same size is a no-op.
        function void set_size(logic [SIZE_W-1:0] v);
            if (v == chip_size)
                return;
            chip_size = v;
            cells.delete();
            erase_hits  = 0;
            other_progs = 0;
        endfunction

        function bit prog_strobe(bit we, bit oe);
            if (chip_size <= SIZE_2K)
                return !we;
            case (chip_size)
                SIZE_8K, SIZE_16K, SIZE_128K, SIZE_256K: return we;
                SIZE_2M, SIZE_4M:                        return oe ? 1'b0 : we;
                default:                                 return oe ? !we : we;
            endcase
        endfunction

        function logic [DATA_W-1:0] word_at(int unsigned a);
            return cells.exists(a) ? cells[a] : WORD_ONES;
        endfunction

        function void note_snapshot(pin_beat_t p);
            result_beat_t r;
            bit           pgm;
            bit           in_range;
            int unsigned  a;
            pgm      = prog_strobe(p.write_enable, p.output_enable);
            a        = 32'(p.address);
            in_range = (a < chip_size) && (a < MEM_DEPTH);
            r.read_data   = WORD_ONES;
            r.read_done   = 1'b0;
            r.write_done  = 1'b0;
            r.range_error = 1'b0;
            r.erased      = 1'b0;
            if (p.supply_on && p.chip_enable && !pgm && p.output_enable)
            begin
                r.read_done = 1'b1;
                if (in_range)
                    r.read_data = word_at(a);
                else
                    r.range_error = 1'b1;
            end
            else if (p.supply_on && p.prog_voltage && p.chip_enable && pgm
                     && !p.output_enable)
            begin
                r.write_done = 1'b1;
                if (in_range)
                begin
                    if (!last_prog_seen || p.address == last_prog_addr)
                        cells[a] = p.write_data;
                    else
                        cells[a] = word_at(a) & p.write_data;
                    last_prog_addr = p.address;
                    last_prog_seen = 1'b1;
                end
                else
                begin
                    r.range_error = 1'b1;
                end
                if (a == 0 && (p.write_data == ERASE_BYTE || p.write_data == WORD_ONES))
                    erase_hits++;
                else
                    other_progs++;
                if (erase_hits > CNT_LIMIT)
                begin
                    cells.delete();
                    erase_hits = 0;
                    r.erased   = 1'b1;
                end
                if (other_progs > CNT_LIMIT)
                begin
                    other_progs = 0;
                    erase_hits  = 0;
                end
            end
            awaited.push_back(r);
        endfunction

        function void report(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(result_beat_t got);
            result_beat_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result beat, read_data %h flags %b%b%b%b", $time,
                         got.read_data, got.read_done, got.write_done, got.range_error,
                         got.erased);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.read_data !== want.read_data)
                report("read_data", want.read_data, got.read_data);
            if (got.read_done !== want.read_done)
                report("read_done", DATA_W'(want.read_done), DATA_W'(got.read_done));
            if (got.write_done !== want.write_done)
                report("write_done", DATA_W'(want.write_done), DATA_W'(got.write_done));
            if (got.range_error !== want.range_error)
                report("range_error", DATA_W'(want.range_error), DATA_W'(got.range_error));
            if (got.erased !== want.erased)
                report("erased", DATA_W'(want.erased), DATA_W'(got.erased));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [SIZE_W-1:0] cfg_wdata = '0;
    bit                steady = 1'b0;   // no idling on either side while set
    int                stall_cycles = 0;

    eprom_scoreboard sb = new();

    eple_in_if  in_ch();
    eple_out_if out_ch();

    eprom_pin_level_emulator #(
        .MEM_DEPTH(MEM_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #4 clk = ~clk;

    // Build a snapshot that forms the requested cycle under the current size.
    // The WE level is chosen at random, then flipped if the decoded strobe
    // disagrees with the cycle wanted; noise leaves every control pin random.
    function automatic pin_beat_t make_snapshot(pin_op_t op, logic [ADDR_W-1:0] addr,
                                                logic [DATA_W-1:0] data);
        pin_beat_t p;
        p.address      = addr;
        p.write_data   = data;
        p.supply_on    = 1'b1;
        p.chip_enable  = 1'b1;
        p.write_enable = 1'($urandom_range(0, 1));
        case (op)
            OP_READ:
            begin
                p.output_enable = 1'b1;
                p.prog_voltage  = 1'($urandom_range(0, 1));
                if (sb.prog_strobe(p.write_enable, 1'b1))
                    p.write_enable = !p.write_enable;
            end
            OP_PROG:
            begin
                p.output_enable = 1'b0;
                p.prog_voltage  = 1'b1;
                if (!sb.prog_strobe(p.write_enable, 1'b0))
                    p.write_enable = !p.write_enable;
            end
            default:
            begin
                p.supply_on     = 1'($urandom_range(0, 1));
                p.chip_enable   = 1'($urandom_range(0, 1));
                p.output_enable = 1'($urandom_range(0, 1));
                p.prog_voltage  = 1'($urandom_range(0, 1));
            end
        endcase
        return p;
    endfunction

    // Mostly well-formed read and program cycles on a handful of words, so
    // that reads see programmed data and programs hit both the replace and
    // the bit-clear paths; the rest roams the valid range, its edge and the bus.
    function automatic pin_beat_t random_snapshot();
        int unsigned       lim;
        int unsigned       pick;
        pin_op_t           op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        lim  = (sb.chip_size < MEM_DEPTH) ? sb.chip_size : MEM_DEPTH;
        pick = $urandom_range(0, 99);
        op   = (pick < 45) ? OP_PROG : (pick < 85) ? OP_READ : OP_NOISE;
        pick = $urandom_range(0, 99);
        if (lim == 0 || pick < 12)
            addr = ADDR_W'($urandom);
        else if (pick < 16)
            addr = ADDR_W'(lim - 1 + $urandom_range(0, 1));   // last valid word or one past it
        else if (pick < 50 && sb.last_prog_seen)
            addr = sb.last_prog_addr;
        else if (pick < 85)
            addr = ADDR_W'($urandom_range(0, (lim < 16) ? lim - 1 : 15));
        else
            addr = ADDR_W'($urandom_range(0, lim - 1));
        pick = $urandom_range(0, 99);
        if (pick < 8)
            data = WORD_ONES;
        else if (pick < 12)
            data = ERASE_BYTE;
        else if (pick < 16)
            data = '0;
        else
            data = DATA_W'($urandom);
        return make_snapshot(op, addr, data);
    endfunction

    // Offer one beat, idling at random first; return at the accepting edge
    // with valid still high so the next beat can follow back to back.
    task automatic send_snapshot(pin_beat_t p);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.supply_on     <= p.supply_on;
        in_ch.prog_voltage  <= p.prog_voltage;
        in_ch.chip_enable   <= p.chip_enable;
        in_ch.write_enable  <= p.write_enable;
        in_ch.output_enable <= p.output_enable;
        in_ch.address       <= p.address;
        in_ch.write_data    <= p.write_data;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_snapshot(p);
    endtask

    // Drop valid and hold until every expected result beat has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    // Write the size only while idle: drained, past the result latency, and
    // with any sweep finished (the sweep holds the input ready low).
    task automatic write_size(logic [SIZE_W-1:0] v);
        drain();
        repeat (2) @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        sb.set_size(v);
        cfg_we <= 1'b0;
    endtask

    // Receive side: check every accepted result beat, stall at random.
    always @(posedge clk)
    begin : result_monitor
        result_beat_t got;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got.read_data   = out_ch.read_data;
            got.read_done   = out_ch.read_done;
            got.write_done  = out_ch.write_done;
            got.range_error = out_ch.range_error;
            got.erased      = out_ch.erased;
            sb.check_result(got);
        end
        out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog: abandon the run after too long without any beat moving.
    always @(posedge clk)
    begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
            || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL eprom_pin_level_emulator");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        logic [SIZE_W-1:0] size_plan [PHASES];
        pin_beat_t         p;
        int                n;
        int                k;

        // Size zero (nothing valid) and the largest size are the extremes;
        // the rest walk every WE decoding branch.
        size_plan = '{SIZE_NONE, SIZE_2K, SIZE_SUB2K, SIZE_8K, SIZE_256K, SIZE_2M,
                      SIZE_4M, SIZE_ODD};

        in_ch.valid         <= 1'b0;
        in_ch.supply_on     <= 1'b0;
        in_ch.prog_voltage  <= 1'b0;
        in_ch.chip_enable   <= 1'b0;
        in_ch.write_enable  <= 1'b0;
        in_ch.output_enable <= 1'b0;
        in_ch.address       <= '0;
        in_ch.write_data    <= '0;

        // Hold reset, then release it once; the block then sweeps its
        // memory before it takes the first beat.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_size(size_plan[phase]);
            steady = (size_plan[phase] == SIZE_8K);

            if (size_plan[phase] == SIZE_2K)
            begin
                // The first in-range program replaces the word outright.
                send_snapshot(make_snapshot(OP_PROG, 22'h000005, 16'h1234));
                send_snapshot(make_snapshot(OP_READ, 22'h000005, '0));
                // A different word than the last program: bits only clear.
                send_snapshot(make_snapshot(OP_PROG, 22'h000006, 16'h0000));
                send_snapshot(make_snapshot(OP_PROG, 22'h000005, 16'hFF00));
                // Same word as the last program: full replace.
                send_snapshot(make_snapshot(OP_PROG, 22'h000005, 16'hABCD));
                send_snapshot(make_snapshot(OP_READ, 22'h000005, '0));
                send_snapshot(make_snapshot(OP_READ, 22'h000006, '0));
                // Last valid word, first word past the end, every address bit set.
                // The out-of-range programs still count, and the sixth
                // non-erase program here clears both counters.
                send_snapshot(make_snapshot(OP_READ, 22'h0007FF, '0));
                send_snapshot(make_snapshot(OP_READ, 22'h000800, '0));
                send_snapshot(make_snapshot(OP_PROG, 22'h000800, 16'h5A5A));
                send_snapshot(make_snapshot(OP_READ, 22'h3FFFFF, '0));
                send_snapshot(make_snapshot(OP_PROG, 22'h3FFFFF, WORD_ONES));
                // No cycle formed: supply off, chip disabled, no programming
                // voltage, and a program strobe with OE also active.
                p = make_snapshot(OP_READ, 22'h000005, '0);
                p.supply_on = 1'b0;
                send_snapshot(p);
                p.supply_on   = 1'b1;
                p.chip_enable = 1'b0;
                send_snapshot(p);
                p = make_snapshot(OP_PROG, 22'h000005, '0);
                p.prog_voltage = 1'b0;
                send_snapshot(p);
                p.prog_voltage  = 1'b1;
                p.output_enable = 1'b1;
                send_snapshot(p);
                // Six erase patterns at word 0 in a row wipe the array.
                for (k = 0; k < 6; k++)
                    send_snapshot(make_snapshot(OP_PROG, '0, k[0] ? WORD_ONES : ERASE_BYTE));
                send_snapshot(make_snapshot(OP_READ, 22'h000005, '0));
            end

            for (n = 0; n < BEATS_PER_PHASE; n++)
            begin
                // Pause once with nothing in flight.
                if (size_plan[phase] == SIZE_256K && n == BEATS_PER_PHASE / 2)
                    drain();
                // An erase run with read-back noise between the patterns.
                if (size_plan[phase] == SIZE_2M && n == 40)
                begin
                    for (k = 0; k < 6; k++)
                    begin
                        if ($urandom_range(0, 2) == 0)
                            send_snapshot(make_snapshot(OP_READ,
                                          ADDR_W'($urandom_range(0, 15)), '0));
                        send_snapshot(make_snapshot(OP_PROG, '0,
                                      $urandom_range(0, 1) ? WORD_ONES : ERASE_BYTE));
                    end
                end
                send_snapshot(random_snapshot());
            end
        end

        // Let the last results come home, then wait on for strays.
        drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS eprom_pin_level_emulator");
        else
            $display("FAIL eprom_pin_level_emulator");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/eple_pkg.sv
hw/rtl/eple_if.sv
hw/rtl/eple_ctrl.sv
hw/rtl/eple_dp.sv
hw/rtl/eprom_pin_level_emulator.sv
hw/rtl/eple_checker.sv
test/tb.sv
